// ----- rtl/fdms_pkg.sv -----
// Shared types, constants and codes for the frame-difference motion settle block.
// Used by every module under rtl/ except fdms_ram; depends on nothing else.
`timescale 1ns / 1ps

package fdms_pkg;

  // Frame geometry
  localparam int unsigned MaxFramePixels = 131072;
  localparam int unsigned AddrW          = $clog2(MaxFramePixels);
  // position saturates one past the maximum frame size
  localparam int unsigned PosW           = $clog2(MaxFramePixels + 2);

  // Field widths
  localparam int unsigned PixW     = 8;
  localparam int unsigned SumW     = 25;
  localparam int unsigned ThrW     = 12;
  localparam int unsigned LimW     = 8;
  localparam int unsigned ProdW    = ThrW + PosW;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [PosW-1:0] PosMax   = PosW'(MaxFramePixels);
  localparam logic [SumW-1:0] SumMax   = '1;
  localparam logic [ThrW-1:0] ThrReset = ThrW'(80);
  localparam logic [LimW-1:0] LimReset = LimW'(30);

  // Opcode of an input beat
  localparam logic OpCompare = 1'b0;
  localparam logic OpLoad    = 1'b1;

  // Register map: register i at byte address 4*i
  typedef enum logic {
    REG_THRESHOLD    = 1'b0,
    REG_SETTLE_LIMIT = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_LOADED   = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_NO_REF   = 2'd2,
    KIND_MISMATCH = 2'd3
  } result_kind_e;

  typedef enum logic [1:0] {
    PH_WAITING  = 2'd0,
    PH_MOVING   = 2'd1,
    PH_SETTLING = 2'd2
  } phase_e;

  // Input beat
  typedef struct packed {
    logic            opcode;
    logic [PixW-1:0] pixel_value;
    logic            end_of_frame;
  } pixel_in_t;

  // Result beat
  typedef struct packed {
    result_kind_e    result_kind;
    logic            motion_seen;
    phase_e          machine_state;
    logic [7:0]      still_frames;
    logic            settled_now;
    logic            move_pending;
    logic [SumW-1:0] frame_diff_sum;
  } result_out_t;

  // Reference store access
  typedef struct packed {
    logic             we;
    logic             re;
    logic [AddrW-1:0] addr;
    logic [PixW-1:0]  wdata;
  } ram_req_t;

  // Pixel leaving the position/control stage
  typedef struct packed {
    logic            eof;
    logic            cmp;
    result_kind_e    kind;
    logic [PixW-1:0] pix;
    logic [PosW-1:0] count;
  } fetch_t;

  // Frame summary entering the settle machine
  typedef struct packed {
    result_kind_e     kind;
    logic [SumW-1:0]  sum;
    logic [ProdW-1:0] limit_prod;
  } frame_t;

endpackage

// ----- rtl/frame_difference_motion_settle_core.sv -----
// Frame-difference motion detector with settle machine: top level and config registers.
// A result beat passes through the s1, s2 and result registers after the last pixel of its frame is accepted.
// Throughput: one pixel per cycle, set by the single reference store port (one access/beat);
//   input stalls only while a finished result is stalled with the next frame's result behind it.
// Reset: control state, machine and registers clear at once; the reference store is not
//   cleared and is undefined until a reference frame is loaded.
`timescale 1ns / 1ps

module frame_difference_motion_settle_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  fdms_pkg::pixel_in_t           in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output fdms_pkg::result_out_t         out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fdms_pkg::CfgAddrW-1:0] paddr,
  input  logic [fdms_pkg::CfgDataW-1:0] pwdata,
  output logic [fdms_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);

  logic [fdms_pkg::ThrW-1:0] thr_q, thr_d;
  logic [fdms_pkg::LimW-1:0] lim_q, lim_d;
  logic                      cfg_we;
  fdms_pkg::reg_idx_e        cfg_idx;

  logic                      hold;
  logic                      advance;
  fdms_pkg::ram_req_t        ram_req;
  logic [fdms_pkg::PixW-1:0] ram_rdata;
  logic                      s1_valid;
  fdms_pkg::fetch_t          s1;
  logic                      s2_valid;
  fdms_pkg::frame_t          s2;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = fdms_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    thr_d = thr_q;
    lim_d = lim_q;
    if (cfg_we) begin
      unique case (cfg_idx)
        fdms_pkg::REG_THRESHOLD:    thr_d = pwdata[fdms_pkg::ThrW-1:0];
        fdms_pkg::REG_SETTLE_LIMIT: lim_d = pwdata[fdms_pkg::LimW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      fdms_pkg::REG_THRESHOLD:    prdata = fdms_pkg::CfgDataW'(thr_q);
      fdms_pkg::REG_SETTLE_LIMIT: prdata = fdms_pkg::CfgDataW'(lim_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= fdms_pkg::ThrReset;
      lim_q <= fdms_pkg::LimReset;
    end else begin
      thr_q <= thr_d;
      lim_q <= lim_d;
    end
  end

  // whole front of the pipe freezes only when a result cannot leave
  assign advance    = !hold;
  assign in_stall_o = hold;

  fdms_frame_ctrl u_frame_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .ram_req_o  (ram_req),
    .s1_valid_o (s1_valid),
    .s1_o       (s1)
  );

  fdms_ram #(
    .Width (fdms_pkg::PixW),
    .Depth (fdms_pkg::MaxFramePixels)
  ) u_ref_store (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .re_i    (ram_req.re),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

  fdms_diff_acc u_diff_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .s1_valid_i (s1_valid),
    .s1_i       (s1),
    .rdata_i    (ram_rdata),
    .thr_i      (thr_q),
    .s2_valid_o (s2_valid),
    .s2_o       (s2)
  );

  fdms_settle_fsm u_settle_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s2_valid_i  (s2_valid),
    .s2_i        (s2),
    .limit_i     (lim_q),
    .out_stall_i (out_stall_i),
    .hold_o      (hold),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/fdms_ram.sv -----
// Generic single-port RAM with registered read, no reset on contents.
// Stand-alone; used for the reference frame store.
`timescale 1ns / 1ps

module fdms_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read, read data holds when not enabled
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/fdms_frame_ctrl.sv -----
// Pixel position tracking, reference bookkeeping and frame classification.
// Issues reference store reads/writes; depends on fdms_pkg.
`timescale 1ns / 1ps

module fdms_frame_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  logic               in_valid_i,
  input  fdms_pkg::pixel_in_t in_data_i,
  output fdms_pkg::ram_req_t  ram_req_o,
  output logic               s1_valid_o,
  output fdms_pkg::fetch_t    s1_o
);

  logic [fdms_pkg::PosW-1:0] pos_q, pos_d;
  logic [fdms_pkg::PosW-1:0] ref_len_q, ref_len_d;
  logic                      ref_valid_q, ref_valid_d;
  logic                      s1_valid_q, s1_valid_d;
  fdms_pkg::fetch_t          s1_q, s1_d;

  logic                      accept;
  logic                      is_load;
  logic                      in_range;
  logic                      do_cmp;
  logic [fdms_pkg::PosW-1:0] pos_inc;
  fdms_pkg::result_kind_e    kind;

  assign accept   = in_valid_i && advance_i;
  assign is_load  = (in_data_i.opcode == fdms_pkg::OpLoad);
  assign in_range = (pos_q < fdms_pkg::PosMax);
  assign pos_inc  = (pos_q <= fdms_pkg::PosMax) ? pos_q + fdms_pkg::PosW'(1) : pos_q;
  assign do_cmp   = !is_load && ref_valid_q && (pos_q < ref_len_q) && in_range;

  // classify the frame as seen at its last beat
  always_comb begin
    priority if (is_load) begin
      kind = (pos_inc > fdms_pkg::PosMax) ? fdms_pkg::KIND_MISMATCH : fdms_pkg::KIND_LOADED;
    end else if (!ref_valid_q) begin
      kind = fdms_pkg::KIND_NO_REF;
    end else if (pos_inc != ref_len_q) begin
      kind = fdms_pkg::KIND_MISMATCH;
    end else begin
      kind = fdms_pkg::KIND_DONE;
    end
  end

  // position and reference state
  always_comb begin
    pos_d       = pos_q;
    ref_len_d   = ref_len_q;
    ref_valid_d = ref_valid_q;
    if (accept) begin
      pos_d = in_data_i.end_of_frame ? '0 : pos_inc;
      if (is_load) begin
        ref_valid_d = in_data_i.end_of_frame && (kind == fdms_pkg::KIND_LOADED);
        if (in_data_i.end_of_frame && (kind == fdms_pkg::KIND_LOADED)) begin
          ref_len_d = pos_inc;
        end
      end
    end
  end

  // hand-off to the difference stage
  always_comb begin
    s1_valid_d = advance_i ? accept : s1_valid_q;
    s1_d.eof   = in_data_i.end_of_frame;
    s1_d.cmp   = do_cmp;
    s1_d.kind  = kind;
    s1_d.pix   = in_data_i.pixel_value;
    s1_d.count = pos_inc;
  end

  // reference store access: one write or one read per beat
  assign ram_req_o.we    = accept && is_load && in_range;
  assign ram_req_o.re    = accept && do_cmp;
  assign ram_req_o.addr  = pos_q[fdms_pkg::AddrW-1:0];
  assign ram_req_o.wdata = in_data_i.pixel_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      ref_len_q   <= '0;
      ref_valid_q <= 1'b0;
      s1_valid_q  <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      ref_len_q   <= ref_len_d;
      ref_valid_q <= ref_valid_d;
      s1_valid_q  <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= fdms_pkg::PosMax + fdms_pkg::PosW'(1))
    else $error("pixel position ran past its saturation point");

  a_load_clears_ref: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_load && !in_data_i.end_of_frame |=> !ref_valid_q)
    else $error("reference still valid during a load frame");

endmodule

// ----- rtl/fdms_diff_acc.sv -----
// Absolute difference against the reference pixel and saturating frame sum.
// Also forms threshold*count for the motion test; depends on fdms_pkg.
`timescale 1ns / 1ps

module fdms_diff_acc (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      advance_i,
  input  logic                      s1_valid_i,
  input  fdms_pkg::fetch_t          s1_i,
  input  logic [fdms_pkg::PixW-1:0] rdata_i,
  input  logic [fdms_pkg::ThrW-1:0] thr_i,
  output logic                      s2_valid_o,
  output fdms_pkg::frame_t          s2_o
);

  logic [fdms_pkg::SumW-1:0] acc_q, acc_d;
  logic                      s2_valid_q, s2_valid_d;
  fdms_pkg::frame_t          s2_q, s2_d;

  logic [fdms_pkg::PixW-1:0] diff;
  logic [fdms_pkg::SumW:0]   sum_wide;
  logic [fdms_pkg::SumW-1:0] sum_sat;

  // |pixel - reference|, zero where the beat does not compare
  always_comb begin
    if (!s1_i.cmp) begin
      diff = '0;
    end else if (rdata_i > s1_i.pix) begin
      diff = rdata_i - s1_i.pix;
    end else begin
      diff = s1_i.pix - rdata_i;
    end
  end

  // saturating accumulate
  assign sum_wide = {1'b0, acc_q} + (fdms_pkg::SumW + 1)'(diff);
  assign sum_sat  = sum_wide[fdms_pkg::SumW] ? fdms_pkg::SumMax : sum_wide[fdms_pkg::SumW-1:0];

  always_comb begin
    acc_d = acc_q;
    if (advance_i && s1_valid_i) begin
      acc_d = s1_i.eof ? '0 : sum_sat;
    end
  end

  // only last beats of a frame move on
  always_comb begin
    s2_valid_d      = advance_i ? (s1_valid_i && s1_i.eof) : s2_valid_q;
    s2_d.kind       = s1_i.kind;
    s2_d.sum        = sum_sat;
    s2_d.limit_prod = fdms_pkg::ProdW'(thr_i) * fdms_pkg::ProdW'(s1_i.count);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      acc_q      <= acc_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      s2_q <= s2_d;
    end
  end

  assign s2_valid_o = s2_valid_q;
  assign s2_o       = s2_q;

  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && s1_valid_i && s1_i.eof |=> acc_q == '0)
    else $error("frame sum not cleared after the last beat");

endmodule

// ----- rtl/fdms_settle_fsm.sv -----
// Motion decision, waiting/moving/settling machine and the result register.
// Drives the pipeline hold; depends on fdms_pkg.
`timescale 1ns / 1ps

module fdms_settle_fsm (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s2_valid_i,
  input  fdms_pkg::frame_t          s2_i,
  input  logic [fdms_pkg::LimW-1:0] limit_i,
  input  logic                      out_stall_i,
  output logic                      hold_o,
  output logic                      out_valid_o,
  output fdms_pkg::result_out_t     out_data_o
);

  fdms_pkg::phase_e          phase_q, phase_d;
  logic [7:0]                cnt_q, cnt_d;
  logic                      move_q, move_d;
  logic                      out_valid_q, out_valid_d;
  fdms_pkg::result_out_t     out_data_q, out_data_d;

  logic                      take;
  logic                      fire;
  logic                      moving;
  logic                      settled;
  logic [7:0]                cnt_inc;
  fdms_pkg::phase_e          phase_n;
  logic [7:0]                cnt_n;
  logic                      move_n;

  // output slot free or draining this cycle
  assign take   = !out_valid_q || !out_stall_i;
  assign fire   = s2_valid_i && take;
  assign hold_o = s2_valid_i && !take;

  // mean > threshold, as sum*16 > threshold_q4*count
  assign moving  = fdms_pkg::ProdW'({s2_i.sum, 4'b0000}) > s2_i.limit_prod;
  assign cnt_inc = (cnt_q != 8'hFF) ? cnt_q + 8'd1 : cnt_q;

  // next machine state for the frame at the head
  always_comb begin
    phase_n = phase_q;
    cnt_n   = cnt_q;
    move_n  = move_q;
    settled = 1'b0;
    unique case (s2_i.kind)
      fdms_pkg::KIND_LOADED: begin
        phase_n = fdms_pkg::PH_WAITING;
        cnt_n   = '0;
        move_n  = 1'b0;
      end
      fdms_pkg::KIND_DONE: begin
        unique case (phase_q)
          fdms_pkg::PH_WAITING: begin
            if (moving) begin
              phase_n = fdms_pkg::PH_MOVING;
              cnt_n   = '0;
            end
          end
          fdms_pkg::PH_MOVING: begin
            if (!moving) begin
              phase_n = fdms_pkg::PH_SETTLING;
              cnt_n   = 8'd1;
            end
          end
          fdms_pkg::PH_SETTLING: begin
            if (moving) begin
              phase_n = fdms_pkg::PH_MOVING;
              cnt_n   = '0;
            end else begin
              cnt_n = cnt_inc;
              if (cnt_inc >= limit_i) begin
                phase_n = fdms_pkg::PH_WAITING;
                move_n  = 1'b1;
                settled = 1'b1;
              end
            end
          end
          default: begin
            phase_n = phase_q;
          end
        endcase
      end
      fdms_pkg::KIND_NO_REF, fdms_pkg::KIND_MISMATCH: begin
        phase_n = phase_q;
      end
    endcase
  end

  // commit and form the result beat
  always_comb begin
    phase_d     = fire ? phase_n : phase_q;
    cnt_d       = fire ? cnt_n : cnt_q;
    move_d      = fire ? move_n : move_q;
    out_valid_d = take ? s2_valid_i : out_valid_q;

    out_data_d.result_kind    = s2_i.kind;
    out_data_d.motion_seen    = (s2_i.kind == fdms_pkg::KIND_DONE) && moving;
    out_data_d.machine_state  = phase_n;
    out_data_d.still_frames   = cnt_n;
    out_data_d.settled_now    = settled;
    out_data_d.move_pending   = move_n;
    out_data_d.frame_diff_sum = (s2_i.kind == fdms_pkg::KIND_DONE) ? s2_i.sum : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= fdms_pkg::PH_WAITING;
      cnt_q       <= '0;
      move_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      move_q      <= move_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_moving_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == fdms_pkg::PH_MOVING |-> cnt_q == '0)
    else $error("still counter nonzero while moving");

  a_settling_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == fdms_pkg::PH_SETTLING |-> cnt_q != '0)
    else $error("still counter zero while settling");

  a_settle_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && settled |=> move_q && phase_q == fdms_pkg::PH_WAITING)
    else $error("settling did not latch the move flag");

endmodule
